// File: design/pqmf_pkg.sv
// ----------------------------------------------------------------------------
// pqmf_pkg
// shared types and constants for the max-first priority queue
// ----------------------------------------------------------------------------
package pqmf_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 32;

    localparam int ITEM_W    = 32;
    localparam int TOP_W     = 32;
    localparam int COUNT_W   = 7;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1 + STATUS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_PEEK   = 2'd2
    } pqmf_req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } pqmf_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TOP,
        S_SU_CHK,
        S_SU_PLACE,
        S_SD_START,
        S_SD_CHK,
        S_REB_READ,
        S_REB_LOAD,
        S_FINISH
    } pqmf_state_t;

    typedef struct packed {
        logic [TOP_W-1:0]   top_value;
        logic               value_valid;
        pqmf_status_t       status;
        logic [COUNT_W-1:0] entry_count;
    } pqmf_result_t;

endpackage

// File: design/pqmf_mem.sv
// ----------------------------------------------------------------------------
// pqmf_mem
// heap key store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module pqmf_mem
    import pqmf_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    parameter int WIDTH = DEF_KEY_WIDTH
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: design/pqmf_ctrl.sv
// ----------------------------------------------------------------------------
// pqmf_ctrl
// binary heap sequencer: sift up, sift down and heap rebuild on order change
// ----------------------------------------------------------------------------
module pqmf_ctrl
    import pqmf_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        order_mode,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  pqmf_req_t                   req,
    input  logic [KEY_WIDTH-1:0]        key,
    input  logic                        out_free,
    output logic                        res_valid,
    output pqmf_result_t                res,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [KEY_WIDTH-1:0]        wr_data,
    output logic [$clog2(CAPACITY)-1:0] rd_addr_a,
    output logic [$clog2(CAPACITY)-1:0] rd_addr_b,
    input  logic [KEY_WIDTH-1:0]        rd_data_a,
    input  logic [KEY_WIDTH-1:0]        rd_data_b
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;

    function automatic logic goes_first(input logic [KEY_WIDTH-1:0] a,
                                        input logic [KEY_WIDTH-1:0] b,
                                        input logic mode);
        return mode ? (a < b) : (a > b);
    endfunction

    pqmf_state_t        state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      j_reg, j_next;
    logic               reb_reg, reb_next;
    logic               heap_order_reg, heap_order_next;
    logic               is_peek_reg, is_peek_next;
    logic [KEY_WIDTH-1:0] val_reg, val_next;
    logic [KEY_WIDTH-1:0] top_reg, top_next;
    logic               valid_reg, valid_next;
    pqmf_status_t       status_reg, status_next;

    logic               mismatch;
    logic [XW-1:0]      lc, rc, klc, klc_r, n_x;
    logic               pick_r;
    logic [KEY_WIDTH-1:0] kid_val;
    logic [IW-1:0]      kid_idx;
    logic [IW-1:0]      par_idx, par_par_idx;
    logic               sd_finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            reb_reg        <= 1'b0;
            heap_order_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            reb_reg        <= reb_next;
            heap_order_reg <= heap_order_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        is_peek_reg <= is_peek_next;
        val_reg     <= val_next;
        top_reg     <= top_next;
        valid_reg   <= valid_next;
        status_reg  <= status_next;
    end

    assign mismatch    = order_mode != heap_order_reg;
    assign n_x         = XW'(count_reg);
    assign lc          = XW'({idx_reg, 1'b1});
    assign rc          = lc + 1'b1;
    assign pick_r      = (rc < n_x) && goes_first(rd_data_b, rd_data_a, order_mode);
    assign kid_val     = pick_r ? rd_data_b : rd_data_a;
    assign kid_idx     = pick_r ? rc[IW-1:0] : lc[IW-1:0];
    assign klc         = XW'({kid_idx, 1'b1});
    assign klc_r       = klc + 1'b1;
    assign par_idx     = (idx_reg - 1'b1) >> 1;
    assign par_par_idx = (par_idx - 1'b1) >> 1;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        reb_next        = reb_reg;
        heap_order_next = heap_order_reg;
        is_peek_next    = is_peek_reg;
        val_next        = val_reg;
        top_next        = top_reg;
        valid_next      = valid_reg;
        status_next     = status_reg;
        rd_addr_a       = '0;
        rd_addr_b       = '0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = val_reg;
        s_tready        = 1'b0;
        res_valid       = 1'b0;
        sd_finish       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready = !mismatch;
                if (mismatch) begin
                    heap_order_next = order_mode;
                    if (count_reg >= CW'(2)) begin
                        j_next     = IW'((count_reg >> 1) - 1'b1);
                        reb_next   = 1'b1;
                        state_next = S_REB_READ;
                    end
                end else if (s_tvalid) begin
                    valid_next  = 1'b0;
                    status_next = STAT_OK;
                    top_next    = '0;
                    state_next  = S_FINISH;
                    case (req)
                        REQ_INSERT: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                status_next = STAT_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                                val_next   = key;
                                idx_next   = count_reg[IW-1:0];
                                if (count_reg == '0) begin
                                    wr_en   = 1'b1;
                                    wr_addr = '0;
                                    wr_data = key;
                                end else begin
                                    rd_addr_a  = IW'((count_reg - 1'b1) >> 1);
                                    state_next = S_SU_CHK;
                                end
                            end
                        end
                        REQ_REMOVE, REQ_PEEK: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                is_peek_next = (req == REQ_PEEK);
                                rd_addr_a    = '0;
                                rd_addr_b    = IW'(count_reg - 1'b1);
                                if (req == REQ_REMOVE) begin
                                    count_next = count_reg - 1'b1;
                                end
                                state_next = S_RD_TOP;
                            end
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_RD_TOP: begin
                top_next   = rd_data_a;
                valid_next = 1'b1;
                if (is_peek_reg || count_reg == '0) begin
                    state_next = S_FINISH;
                end else begin
                    val_next   = rd_data_b;
                    idx_next   = '0;
                    state_next = S_SD_START;
                end
            end
            S_SU_CHK: begin
                wr_en = 1'b1;
                if (goes_first(val_reg, rd_data_a, order_mode)) begin
                    wr_data  = rd_data_a;
                    idx_next = par_idx;
                    if (par_idx == '0) begin
                        state_next = S_SU_PLACE;
                    end else begin
                        rd_addr_a = par_par_idx;
                    end
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SU_PLACE: begin
                wr_en      = 1'b1;
                state_next = S_FINISH;
            end
            S_SD_START: begin
                if (lc >= n_x) begin
                    wr_en     = 1'b1;
                    sd_finish = 1'b1;
                end else begin
                    rd_addr_a  = lc[IW-1:0];
                    rd_addr_b  = rc[IW-1:0];
                    state_next = S_SD_CHK;
                end
            end
            S_SD_CHK: begin
                wr_en = 1'b1;
                if (goes_first(kid_val, val_reg, order_mode)) begin
                    wr_data  = kid_val;
                    idx_next = kid_idx;
                    if (klc < n_x) begin
                        rd_addr_a = klc[IW-1:0];
                        rd_addr_b = klc_r[IW-1:0];
                    end else begin
                        state_next = S_SD_START;
                    end
                end else begin
                    sd_finish = 1'b1;
                end
            end
            S_REB_READ: begin
                rd_addr_a  = j_reg;
                state_next = S_REB_LOAD;
            end
            S_REB_LOAD: begin
                val_next   = rd_data_a;
                idx_next   = j_reg;
                state_next = S_SD_START;
            end
            S_FINISH: begin
                res_valid = out_free;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (sd_finish) begin
            if (reb_reg) begin
                if (j_reg == '0) begin
                    reb_next   = 1'b0;
                    state_next = S_IDLE;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_REB_READ;
                end
            end else begin
                state_next = S_FINISH;
            end
        end
    end

    assign res.top_value   = TOP_W'(top_reg);
    assign res.value_valid = valid_reg;
    assign res.status      = status_reg;
    assign res.entry_count = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (XW'(wr_addr) < XW'(count_next)))
        else $error("heap write outside held entries");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && req == REQ_INSERT && count_reg < CW'(CAPACITY))
        |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("insert did not add an entry");

    a_no_accept_rebuild: assert property (@(posedge aclk) disable iff (!aresetn)
        reb_reg |-> !s_tready)
        else $error("transaction accepted during heap rebuild");

    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.value_valid) |-> (res.status == STAT_OK))
        else $error("key reported with error status");

endmodule

// File: design/priority_queue_max_first_top.sv
// Insert writes the key at the tail and sifts it up (an empty queue takes a direct write); peek reads the root;
// remove reads the root and the tail key, then sifts the tail key down from the root.
// One transaction in flight; the next is taken once the result registers and no rebuild is pending.
// An order_mode change re-heapifies the store (two or more keys held) before the next transaction:
// count/2 sift-downs from the last parent to the root, s_tready low meanwhile.
// Reset clears the entry count and order; the key memory is not cleared.
// ----------------------------------------------------------------------------
// priority_queue_max_first_top
// bounded priority queue of unsigned keys on a binary heap in block memory
// ----------------------------------------------------------------------------
module priority_queue_max_first_top
    import pqmf_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_data,   // order_mode
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // item_value
    input  logic [S_TUSER_W-1:0] s_tuser,    // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // top_value, entry_count, zero pad
    output logic [M_TUSER_W-1:0] m_tuser     // value_valid, status
);

    localparam int IW = $clog2(CAPACITY);

    logic                 order_mode_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic                 out_free;
    logic                 res_valid;
    pqmf_result_t         res;

    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic [IW-1:0]        rd_addr_a;
    logic [IW-1:0]        rd_addr_b;
    logic [KEY_WIDTH-1:0] rd_data_a;
    logic [KEY_WIDTH-1:0] rd_data_b;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                order_mode_reg <= cfg_data[0];
            end
            if (res_valid) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= M_TDATA_W'({res.entry_count, res.top_value});
            m_tuser_reg <= {res.status, res.value_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    pqmf_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .order_mode (order_mode_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req        (pqmf_req_t'(s_tuser)),
        .key        (KEY_WIDTH'(s_tdata)),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .rd_data_a  (rd_data_a),
        .rd_data_b  (rd_data_b)
    );

    pqmf_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule

// File: sim/tb_priority_queue_max_first_top.sv
// ----------------------------------------------------------------------------
// tb_priority_queue_max_first_top
// self-checking bench for the bounded priority queue: a scoreboard keeps its
// own flat copy of the held keys and predicts every result; requests, order
// writes and drain pauses are queued up front and sent with random gaps,
// while the result side stalls at random
// ----------------------------------------------------------------------------
module tb_priority_queue_max_first_top
    import pqmf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int ITEM_TARGET  = 950;
    localparam int HANG_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_PRINTS   = 30;

    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
    localparam logic ORDER_MAX_FIRST = 1'b0;
    localparam logic ORDER_MIN_FIRST = 1'b1;

    typedef enum logic [1:0] {
        ACT_REQ,
        ACT_ORDER,
        ACT_DRAIN
    } act_kind_t;

    typedef struct {
        act_kind_t          kind;
        logic [REQ_W-1:0]   req;
        logic [ITEM_W-1:0]  key;
        logic               order;
        int unsigned        idle;
    } act_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [0:0]           cfg_data  = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // item_value
    logic [S_TUSER_W-1:0] s_tuser   = '0;   // req_type
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // top_value, entry_count, zero pad
    logic [M_TUSER_W-1:0] m_tuser;          // value_valid, status

    act_t               pending_acts[$];
    pqmf_result_t       expected_results[$];

    logic [ITEM_W-1:0]  held_keys [CAPACITY];
    int                 held_cnt   = 0;
    logic               order_sel  = ORDER_MAX_FIRST;

    int unsigned        n_predicted = 0;
    int unsigned        n_checked   = 0;
    int unsigned        n_errors    = 0;
    int unsigned        n_queued    = 0;
    int unsigned        n_full      = 0;
    int unsigned        n_empty     = 0;
    int unsigned        n_served    = 0;
    int unsigned        n_orders    = 0;
    int unsigned        gap_cnt     = 0;
    int unsigned        stall_left  = 0;
    int unsigned        quiet_cnt   = 0;

    priority_queue_max_first_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic pqmf_result_t serve_request(logic [REQ_W-1:0] req,
                                                   logic [ITEM_W-1:0] key);
        pqmf_result_t r;
        int           best;
        r        = '0;
        r.status = STAT_OK;
        case (req)
            REQ_INSERT: begin
                if (held_cnt >= CAPACITY) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    held_keys[held_cnt] = key;
                    held_cnt++;
                end
            end
            REQ_REMOVE, REQ_PEEK: begin
                if (held_cnt == 0) begin
                    r.status = STAT_EMPTY;
                    n_empty++;
                end else begin
                    best = 0;
                    for (int i = 1; i < held_cnt; i++) begin
                        if (order_sel == ORDER_MIN_FIRST ? held_keys[i] < held_keys[best]
                                                         : held_keys[i] > held_keys[best])
                            best = i;
                    end
                    r.top_value   = held_keys[best];
                    r.value_valid = 1'b1;
                    n_served++;
                    if (req == REQ_REMOVE) begin
                        held_keys[best] = held_keys[held_cnt-1];
                        held_cnt--;
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_W'(held_cnt);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got,
                                   longint unsigned want);
        if (n_errors < MAX_PRINTS)
            $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                     $realtime, n_checked, field, got, want);
        n_errors++;
    endtask

    function automatic logic [ITEM_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return ITEM_W'($urandom_range(0, 15));
            1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                                 : ITEM_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_req(logic [REQ_W-1:0] req, logic [ITEM_W-1:0] key,
                                    int unsigned idle);
        act_t a;
        a.kind  = ACT_REQ;
        a.req   = req;
        a.key   = key;
        a.order = 1'b0;
        a.idle  = idle;
        pending_acts.push_back(a);
        n_queued++;
    endfunction

    function automatic void add_order(logic order);
        act_t a;
        a.kind  = ACT_ORDER;
        a.req   = REQ_NOP;
        a.key   = '0;
        a.order = order;
        a.idle  = 0;
        pending_acts.push_back(a);
    endfunction

    function automatic void add_drain();
        act_t a;
        a.kind  = ACT_DRAIN;
        a.req   = REQ_NOP;
        a.key   = '0;
        a.order = 1'b0;
        a.idle  = 0;
        pending_acts.push_back(a);
    endfunction

    function automatic logic [REQ_W-1:0] pick_mixed_req();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)      return REQ_INSERT;
        else if (roll < 80) return REQ_REMOVE;
        else if (roll < 95) return REQ_PEEK;
        else                return REQ_NOP;
    endfunction

    // transaction driver for requests and order writes
    always @(posedge aclk) begin : feed_proc
        logic nxt_tvalid;
        logic nxt_cvalid;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_valid <= 1'b0;
            gap_cnt   <= 0;
        end else begin
            nxt_tvalid = s_tvalid;
            nxt_cvalid = cfg_valid;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(serve_request(s_tuser, s_tdata));
                n_predicted <= n_predicted + 1;
                nxt_tvalid = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                order_sel = cfg_data[0];
                n_orders++;
                nxt_cvalid = 1'b0;
            end
            if (!nxt_tvalid && !nxt_cvalid && pending_acts.size() > 0) begin
                case (pending_acts[0].kind)
                    ACT_REQ: begin
                        if (gap_cnt < pending_acts[0].idle) begin
                            gap_cnt <= gap_cnt + 1;
                        end else begin
                            s_tuser    <= pending_acts[0].req;
                            s_tdata    <= pending_acts[0].key;
                            nxt_tvalid = 1'b1;
                            gap_cnt    <= 0;
                            pending_acts.delete(0);
                        end
                    end
                    ACT_ORDER: begin
                        if (n_predicted == n_checked && !s_tvalid) begin
                            cfg_data   <= pending_acts[0].order;
                            nxt_cvalid = 1'b1;
                            pending_acts.delete(0);
                        end
                    end
                    default: begin
                        if (n_predicted == n_checked && !s_tvalid)
                            pending_acts.delete(0);
                    end
                endcase
            end
            s_tvalid  <= nxt_tvalid;
            cfg_valid <= nxt_cvalid;
        end
    end

    // result monitor and scoreboard
    always @(posedge aclk) begin : check_proc
        pqmf_result_t got;
        pqmf_result_t want;
        int unsigned  nxt_stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            got.top_value   = m_tdata[TOP_W-1:0];
            got.entry_count = m_tdata[TOP_W +: COUNT_W];
            got.value_valid = m_tuser[0];
            got.status      = pqmf_status_t'(m_tuser[1 +: STATUS_W]);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, top_value", got.top_value, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.top_value !== want.top_value)
                    report_mismatch("top_value", got.top_value, want.top_value);
                if (got.value_valid !== want.value_valid)
                    report_mismatch("value_valid", got.value_valid, want.value_valid);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", got.entry_count, want.entry_count);
            end
            n_checked <= n_checked + 1;
            nxt_stall = (n_checked % 256 < 48) ? 0 : $urandom_range(0, 11);
            stall_left <= nxt_stall;
            m_tready   <= (nxt_stall == 0);
        end else if (!m_tready) begin
            m_tready   <= (stall_left <= 1);
            stall_left <= (stall_left == 0) ? 0 : stall_left - 1;
        end
    end

    always @(posedge aclk) begin : watchdog_proc
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= HANG_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, HANG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial begin : stim_proc
        int unsigned phase;
        int unsigned len;
        logic        steady;
        logic [REQ_W-1:0] req;

        // directed: empty queue, extreme keys, duplicates, no-op code, order flips
        add_req(REQ_PEEK,   32'hFFFF_FFFF, 0);
        add_req(REQ_REMOVE, 32'h0000_0000, 0);
        add_req(REQ_NOP,    32'hA5A5_A5A5, 0);
        add_req(REQ_INSERT, 32'h0000_0000, 0);
        add_req(REQ_INSERT, 32'hFFFF_FFFF, 0);
        add_req(REQ_INSERT, 32'h8000_0000, 1);
        add_req(REQ_INSERT, 32'h7FFF_FFFF, 0);
        add_req(REQ_INSERT, 32'h0000_0001, 2);
        add_req(REQ_INSERT, 32'hFFFF_FFFF, 0);
        add_req(REQ_PEEK,   32'h5A5A_5A5A, 0);
        add_req(REQ_NOP,    32'hFFFF_FFFF, 0);
        add_order(ORDER_MIN_FIRST);
        add_req(REQ_PEEK,   32'hFFFF_FFFF, 0);
        add_req(REQ_REMOVE, 32'h0000_0000, 0);
        add_req(REQ_REMOVE, 32'h0000_0000, 3);
        add_order(ORDER_MAX_FIRST);
        for (int i = 0; i < 5; i++)
            add_req(REQ_REMOVE, $urandom, 0);

        // random phases: fill past full, drain past empty, mixed traffic
        while (n_queued < ITEM_TARGET) begin
            phase  = $urandom_range(0, 5);
            steady = ($urandom_range(0, 3) == 0);
            if (phase == 5)
                add_order(1'($urandom_range(0, 1)));
            len = (phase <= 1) ? 70 : $urandom_range(20, 50);
            for (int i = 0; i < len; i++) begin
                case (phase)
                    0:       req = ($urandom_range(0, 9) == 0) ? REQ_PEEK : REQ_INSERT;
                    1:       req = ($urandom_range(0, 9) == 0) ? REQ_PEEK : REQ_REMOVE;
                    default: req = pick_mixed_req();
                endcase
                add_req(req, pick_key(), steady ? 0 : $urandom_range(0, 11));
            end
            if (n_queued > ITEM_TARGET / 2 && n_queued < ITEM_TARGET / 2 + 80)
                add_drain();
            else if ($urandom_range(0, 7) == 0)
                add_drain();
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_acts.size() > 0 || s_tvalid || cfg_valid || n_predicted != n_checked)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests and %0d order writes; %0d keys served,",
                 n_checked, n_orders, n_served);
        $display("%0d inserts refused on a full queue, %0d requests on an empty one",
                 n_full, n_empty);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
